@@ hw/rtl/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// drs_pkg
// shared types and constants for the disk request scheduler
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int QueueDepthDefault = 16;
	localparam int CountW            = 5;

	localparam logic FUNC_ARRIVE   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	localparam logic POLICY_FCFS = 1'b0;
	localparam logic POLICY_SSTF = 1'b1;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] atime;
		logic [15:0] cyl;
		logic [31:0] addr;
		logic [15:0] pid;
	} req_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;    // capture the input word
		logic arrive;      // do the arrival update
		logic scan_start;  // clear scan position and best-so-far
		logic scan_step;   // compare one slot
		logic take;        // read best slot into serving, start shift
		logic shift_step;  // move one entry down
		logic go_idle;     // empty completion
		logic load_out;    // load the result register
	} drs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic func;
		logic empty;
		logic scan_done;
		logic shift_done;
	} drs_sts_t;

endpackage

@@ hw/rtl/drs_datapath.sv @@
// ----------------------------------------------------------------------------
// drs_datapath
// queue memory, serving register, best-slot scan and order-keeping shift
// ----------------------------------------------------------------------------
module drs_datapath #(
	parameter int QUEUE_DEPTH = drs_pkg::QueueDepthDefault,
	localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int FillW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  drs_pkg::drs_cmd_t      cmd,
	output drs_pkg::drs_sts_t      sts,
	input  logic                   policy,
	input  logic                   in_func,
	input  drs_pkg::req_t          in_req,
	input  logic [15:0]            in_head,
	output logic                   res_busy,
	output drs_pkg::req_t          res_req,
	output logic [drs_pkg::CountW-1:0] res_count,
	output logic                   res_dropped
);

	drs_pkg::req_t mem [QUEUE_DEPTH];

	drs_pkg::req_t   req_q;
	logic            func_q;
	logic [15:0]     head_q;
	drs_pkg::req_t   serve_q;
	logic            busy_q;
	logic [FillW-1:0] fill_q;
	logic            drop_q;

	logic [FillW-1:0] scan_q;   // next slot to read; rd_q holds slot scan_q - 1
	logic             rd_pend_q;
	drs_pkg::req_t    rd_q;
	logic [IdxW-1:0]  best_q;
	logic [31:0]      best_time_q;
	logic [15:0]      best_dist_q;
	logic             have_best_q;
	logic [FillW-1:0] sh_q;     // shift destination

	logic [IdxW-1:0] rd_addr;
	logic [15:0]     rd_dist;
	logic            better;

	always_comb begin
		rd_dist = (rd_q.cyl >= head_q) ? (rd_q.cyl - head_q) : (head_q - rd_q.cyl);
		if (!have_best_q)
			better = 1'b1;
		else if (policy == drs_pkg::POLICY_FCFS)
			better = rd_q.atime < best_time_q;
		else
			better = (rd_dist < best_dist_q) ||
				(rd_dist == best_dist_q && rd_q.atime < best_time_q);
	end

	// read address: during scan the next slot, during take/shift the source
	// (while shifting, read two slots past the slot being written)
	always_comb begin
		rd_addr = scan_q[IdxW-1:0];
		if (cmd.take)
			rd_addr = best_q;
		else if (cmd.shift_step)
			rd_addr = rd_pend_q ? IdxW'(sh_q + FillW'(2)) : IdxW'(sh_q + FillW'(1));
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.arrive && busy_q && fill_q < FillW'(QUEUE_DEPTH))
			mem[fill_q[IdxW-1:0]] <= req_q;
		else if (cmd.shift_step && rd_pend_q)
			mem[sh_q[IdxW-1:0]] <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
			drop_q <= 1'b0;
			scan_q <= '0;
			rd_pend_q <= 1'b0;
			have_best_q <= 1'b0;
			sh_q <= '0;
			res_busy <= 1'b0;
			res_count <= '0;
			res_dropped <= 1'b0;
			serve_q <= '0;
		end else begin
			if (cmd.latch_in) begin
				drop_q <= 1'b0;
				rd_pend_q <= 1'b0;
			end
			if (cmd.arrive) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
					serve_q <= req_q;
				end else if (fill_q < FillW'(QUEUE_DEPTH)) begin
					fill_q <= fill_q + FillW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.go_idle) begin
				busy_q <= 1'b0;
				serve_q <= '0;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				have_best_q <= 1'b0;
				rd_pend_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				// issue a read each cycle; judge the one that came back
				if (rd_pend_q && better) begin
					best_q <= IdxW'(scan_q - FillW'(1));
					best_time_q <= rd_q.atime;
					best_dist_q <= rd_dist;
					have_best_q <= 1'b1;
				end
				if (scan_q < fill_q) begin
					scan_q <= scan_q + FillW'(1);
					rd_pend_q <= 1'b1;
				end else begin
					rd_pend_q <= 1'b0;
				end
			end
			if (cmd.take) begin
				sh_q <= FillW'(best_q);
				rd_pend_q <= 1'b0;
				have_best_q <= 1'b0;
			end
			if (cmd.shift_step) begin
				if (!rd_pend_q && sh_q == FillW'(best_q) && !have_best_q) begin
					serve_q <= rd_q;  // first cycle: selected entry read back
					have_best_q <= 1'b1;
					busy_q <= 1'b1;
					rd_pend_q <= 1'b1;
				end else if (rd_pend_q) begin
					sh_q <= sh_q + FillW'(1);
				end
				if (sts.shift_done)
					fill_q <= fill_q - FillW'(1);
			end
			if (cmd.load_out) begin
				res_busy <= busy_q;
				res_count <= drs_pkg::CountW'(fill_q);
				res_dropped <= drop_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			req_q <= in_req;
			func_q <= in_func;
			head_q <= in_head;
		end
		if (cmd.load_out)
			res_req <= busy_q ? serve_q : '0;
	end

	always_comb begin
		sts.func = func_q;
		sts.empty = (fill_q == '0);
		sts.scan_done = (scan_q >= fill_q) && !rd_pend_q;
		sts.shift_done = rd_pend_q &&
			(({1'b0, sh_q} + (FillW + 1)'(2)) >= {1'b0, fill_q});
	end

endmodule

@@ hw/rtl/drs_ctrl.sv @@
// ----------------------------------------------------------------------------
// drs_ctrl
// sequencer for arrival, scan, take and shift of the scheduler
// ----------------------------------------------------------------------------
module drs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	output logic              in_rdy,
	output logic              out_vld,
	output drs_pkg::drs_cmd_t cmd,
	input  drs_pkg::drs_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN, S_TAKE, S_SHIFT, S_RESULT, S_HOLD
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.latch_in = in_fire;
		case (state_q)
			S_DECODE: begin
				if (sts.func == drs_pkg::FUNC_ARRIVE)
					cmd.arrive = 1'b1;
				else if (sts.empty)
					cmd.go_idle = 1'b1;
				else
					cmd.scan_start = 1'b1;
			end
			S_SCAN:   cmd.scan_step = 1'b1;
			S_TAKE:   cmd.take = 1'b1;
			S_SHIFT:  cmd.shift_step = 1'b1;
			S_RESULT: cmd.load_out = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_rdy <= 1'b1;
			out_vld <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_DECODE;
					in_rdy <= 1'b0;
				end
				S_DECODE: begin
					if (sts.func == drs_pkg::FUNC_ARRIVE || sts.empty)
						state_q <= S_RESULT;
					else
						state_q <= S_SCAN;
				end
				S_SCAN:  if (sts.scan_done) state_q <= S_TAKE;
				S_TAKE:  state_q <= S_SHIFT;
				S_SHIFT: if (sts.shift_done) state_q <= S_RESULT;
				S_RESULT: begin
					state_q <= S_HOLD;
					out_vld <= 1'b1;
				end
				S_HOLD: if (out_fire) begin
					state_q <= S_IDLE;
					out_vld <= 1'b0;
					in_rdy <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/disk_request_scheduler.sv @@
// Sequence (accepting edge to out_valid high): an arrival or empty completion passes
// decode and result; a completion with pending requests adds scan, take and shift
// (one memory read per scan slot, then one per shifted entry through the queue memory).
// Throughput: one word at a time; next word taken after the result is taken.
// Reset (arst_n low): idle, queue empty, policy FCFS; queue memory not cleared.
// ----------------------------------------------------------------------------
// disk_request_scheduler
// FCFS / SSTF disk request scheduler with an order-keeping pending queue
// ----------------------------------------------------------------------------
module disk_request_scheduler #(
	parameter int QUEUE_DEPTH = drs_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] rq_tag,
	input  logic [31:0] arrival_time,
	input  logic [15:0] cylinder,
	input  logic [31:0] block_address,
	input  logic [15:0] owner_tag,
	input  logic [15:0] head_cylinder,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        served_valid,
	output logic [15:0] served_rq_tag,
	output logic [31:0] served_arrival_time,
	output logic [15:0] served_cylinder,
	output logic [31:0] served_block_address,
	output logic [15:0] served_owner_tag,
	output logic [4:0]  pending_count,
	output logic        dropped
);

	logic policy_q;
	drs_pkg::drs_cmd_t cmd;
	drs_pkg::drs_sts_t sts;
	drs_pkg::req_t in_req, res_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			policy_q <= drs_pkg::POLICY_FCFS;
		else if (cfg_we)
			policy_q <= cfg_wdata;
	end

	assign in_req = '{id: rq_tag, atime: arrival_time, cyl: cylinder,
		addr: block_address, pid: owner_tag};

	drs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_valid && in_ready), .out_fire(out_valid && out_ready),
		.in_rdy(in_ready), .out_vld(out_valid), .cmd(cmd), .sts(sts)
	);

	drs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .policy(policy_q),
		.in_func(func), .in_req(in_req), .in_head(head_cylinder),
		.res_busy(served_valid), .res_req(res_req), .res_count(pending_count),
		.res_dropped(dropped)
	);

	assign served_rq_tag        = res_req.id;
	assign served_arrival_time  = res_req.atime;
	assign served_cylinder      = res_req.cyl;
	assign served_block_address = res_req.addr;
	assign served_owner_tag     = res_req.pid;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while word pending");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !served_valid |-> served_rq_tag == '0)
		else $error("idle result not zero");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_count <= 5'(QUEUE_DEPTH)) else $error("count overrun");
`endif

endmodule

@@ tb/disk_request_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk_request_scheduler_tb
// drives arrivals and completions under both policies, predicts the served
// request and queue state in a behavioural copy, compares every result word
// ----------------------------------------------------------------------------
module disk_request_scheduler_tb;

	localparam int Depth = drs_pkg::QueueDepthDefault;
	localparam int WatchdogLimit = 20000;

	typedef struct packed {
		logic        srv_valid;
		logic [15:0] id;
		logic [31:0] atime;
		logic [15:0] cyl;
		logic [31:0] addr;
		logic [15:0] pid;
		logic [4:0]  count;
		logic        drop;
	} served_t;

	typedef struct {
		logic        fn;
		logic [15:0] id;
		logic [31:0] atime;
		logic [15:0] cyl;
		logic [31:0] addr;
		logic [15:0] pid;
		logic [15:0] head;
		logic        typed;
		served_t     want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0, cfg_wdata = 1'b0;
	logic in_valid = 1'b0, out_ready = 1'b0;
	logic in_ready, out_valid;
	logic        func = drs_pkg::FUNC_ARRIVE;
	logic [15:0] rq_tag = '0, cylinder = '0, owner_tag = '0, head_cylinder = '0;
	logic [31:0] arrival_time = '0, block_address = '0;
	logic        served_valid, dropped;
	logic [15:0] served_rq_tag, served_cylinder, served_owner_tag;
	logic [31:0] served_arrival_time, served_block_address;
	logic [4:0]  pending_count;

	disk_request_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.rq_tag(rq_tag), .arrival_time(arrival_time), .cylinder(cylinder),
		.block_address(block_address), .owner_tag(owner_tag),
		.head_cylinder(head_cylinder), .out_valid(out_valid), .out_ready(out_ready),
		.served_valid(served_valid), .served_rq_tag(served_rq_tag),
		.served_arrival_time(served_arrival_time), .served_cylinder(served_cylinder),
		.served_block_address(served_block_address),
		.served_owner_tag(served_owner_tag), .pending_count(pending_count),
		.dropped(dropped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic   policy;
	logic   busy_q;
	drs_pkg::req_t serving;
	drs_pkg::req_t waiting [Depth];
	int     fill;
	served_t served_queue [$];
	int     failures = 0;
	int     idle_cycles = 0;
	int     words_sent = 0, words_seen = 0, drops_seen = 0, sstf_words = 0;
	logic   done_flag = 1'b0;

	function automatic logic [15:0] seek_dist(logic [15:0] a, logic [15:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic served_t predict_served(logic fn, drs_pkg::req_t r,
		logic [15:0] head);
		served_t o;
		int best;
		logic better;
		o.drop = 1'b0;
		if (fn == drs_pkg::FUNC_ARRIVE) begin
			if (!busy_q) begin
				busy_q = 1'b1;
				serving = r;
			end else if (fill < Depth) begin
				waiting[fill] = r;
				fill++;
			end else begin
				o.drop = 1'b1;
			end
		end else if (fill == 0) begin
			busy_q = 1'b0;
			serving = '0;
		end else begin
			best = 0;
			for (int i = 1; i < fill; i++) begin
				if (policy == drs_pkg::POLICY_FCFS)
					better = waiting[i].atime < waiting[best].atime;
				else
					better = seek_dist(waiting[i].cyl, head) < seek_dist(waiting[best].cyl, head)
						|| (seek_dist(waiting[i].cyl, head) == seek_dist(waiting[best].cyl, head)
						&& waiting[i].atime < waiting[best].atime);
				if (better)
					best = i;
			end
			serving = waiting[best];
			busy_q = 1'b1;
			for (int i = best; i + 1 < fill; i++)
				waiting[i] = waiting[i + 1];
			fill--;
		end
		o.srv_valid = busy_q;
		o.id    = busy_q ? serving.id : '0;
		o.atime = busy_q ? serving.atime : '0;
		o.cyl   = busy_q ? serving.cyl : '0;
		o.addr  = busy_q ? serving.addr : '0;
		o.pid   = busy_q ? serving.pid : '0;
		o.count = fill[4:0];
		return o;
	endfunction

	task automatic idle_for(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_policy(logic p);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = p;
	endtask

	// valid stays up after a handshake only until the next word or drain
	task automatic send_word(logic fn, logic [15:0] id, logic [31:0] at, logic [15:0] cy,
		logic [31:0] ad, logic [15:0] pd, logic [15:0] hd, logic typed, served_t want);
		drs_pkg::req_t r;
		served_t got;
		int gap;
		r = '{id: id, atime: at, cyl: cy, addr: ad, pid: pd};
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			idle_for(gap);
		end
		func <= fn; rq_tag <= id; arrival_time <= at; cylinder <= cy;
		block_address <= ad; owner_tag <= pd; head_cylinder <= hd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		got = predict_served(fn, r, hd);
		if (typed && got != want) begin
			$error("typed row disagrees with predictor: %h vs %h", want, got);
			failures++;
		end
		served_queue.push_back(got);
		words_sent++;
		if (policy == drs_pkg::POLICY_SSTF && fn == drs_pkg::FUNC_COMPLETE)
			sstf_words++;
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		while (served_queue.size() != 0)
			@(posedge clk);
		idle_for(2 * Depth + 10);
	endtask

	// random request; small pool of cylinders and times to provoke ties
	task automatic send_random(int arrive_pct);
		logic fn;
		logic [31:0] at;
		logic [15:0] cy, hd;
		fn = ($urandom_range(0, 99) < arrive_pct) ? drs_pkg::FUNC_ARRIVE
			: drs_pkg::FUNC_COMPLETE;
		at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
		cy = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		hd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		send_word(fn, 16'($urandom), at, cy, $urandom, 16'($urandom), hd, 1'b0, '0);
	endtask

	// result side
	always @(posedge clk) begin
		served_t exp_w;
		if (out_valid && out_ready) begin
			words_seen++;
			if (dropped) drops_seen++;
			if (served_queue.size() == 0) begin
				$error("result word with nothing expected");
				failures++;
			end else begin
				exp_w = served_queue.pop_front();
				if (served_valid !== exp_w.srv_valid) begin
					$error("served_valid exp %0d got %0d", exp_w.srv_valid, served_valid);
					failures++;
				end
				if (served_rq_tag !== exp_w.id) begin
					$error("served_rq_tag exp %h got %h", exp_w.id, served_rq_tag);
					failures++;
				end
				if (served_arrival_time !== exp_w.atime) begin
					$error("served_arrival_time exp %h got %h", exp_w.atime,
						served_arrival_time);
					failures++;
				end
				if (served_cylinder !== exp_w.cyl) begin
					$error("served_cylinder exp %h got %h", exp_w.cyl, served_cylinder);
					failures++;
				end
				if (served_block_address !== exp_w.addr) begin
					$error("served_block_address exp %h got %h", exp_w.addr,
						served_block_address);
					failures++;
				end
				if (served_owner_tag !== exp_w.pid) begin
					$error("served_owner_tag exp %h got %h", exp_w.pid, served_owner_tag);
					failures++;
				end
				if (pending_count !== exp_w.count) begin
					$error("pending_count exp %0d got %0d", exp_w.count, pending_count);
					failures++;
				end
				if (dropped !== exp_w.drop) begin
					$error("dropped exp %0d got %0d", exp_w.drop, dropped);
					failures++;
				end
			end
		end
	end

	// receiver stalls: randomly hold ready low before each word
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || done_flag)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		served_t w;
		policy = drs_pkg::POLICY_FCFS;
		busy_q = 1'b0;
		serving = '0;
		fill = 0;
		foreach (waiting[i]) waiting[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: completion while idle, extremes, fill to full, drop, ties
		w = '0;
		rows.push_back('{drs_pkg::FUNC_COMPLETE, 16'h0, 32'h0, 16'h0, 32'h0, 16'h0,
			16'hffff, 1'b1, w});
		w = '{1'b1, 16'hffff, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 5'd0, 1'b0};
		rows.push_back('{drs_pkg::FUNC_ARRIVE, 16'hffff, 32'hffffffff, 16'hffff,
			32'hffffffff, 16'hffff, 16'h0, 1'b1, w});
		for (int i = 0; i < Depth; i++)
			rows.push_back('{drs_pkg::FUNC_ARRIVE, 16'(i + 1), 32'(100 - (i % 5)),
				16'(i * 1000), 32'(i), 16'(i), 16'h0, 1'b0, '0});
		w = '{1'b1, 16'hffff, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 5'd16, 1'b1};
		rows.push_back('{drs_pkg::FUNC_ARRIVE, 16'h0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0,
			1'b1, w});
		for (int i = 0; i < 4; i++)
			rows.push_back('{drs_pkg::FUNC_COMPLETE, 16'h0, 32'h0, 16'h0, 32'h0, 16'h0,
				16'(i * 7000), 1'b0, '0});
		foreach (rows[i])
			send_word(rows[i].fn, rows[i].id, rows[i].atime, rows[i].cyl, rows[i].addr,
				rows[i].pid, rows[i].head, rows[i].typed, rows[i].want);
		drain_wait();

		// sstf over the leftover queue, tie-heavy heads, then drain to idle
		write_policy(drs_pkg::POLICY_SSTF);
		repeat (Depth) send_word(drs_pkg::FUNC_COMPLETE, '0, '0, '0, '0, '0, 16'(3000),
			1'b0, '0);
		drain_wait();

		// random phases alternating policy; arrival bias swings the queue fill
		for (int ph = 0; ph < 8; ph++) begin
			write_policy(ph[0]);
			for (int k = 0; k < 210; k++)
				send_random((k % 70 < 40) ? 75 : 35);
			drain_wait();
		end
		done_flag = 1'b1;

		$display("sent %0d words, %0d results, %0d drops, %0d sstf completions",
			words_sent, words_seen, drops_seen, sstf_words);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/drs_pkg.sv
hw/rtl/drs_datapath.sv
hw/rtl/drs_ctrl.sv
hw/rtl/disk_request_scheduler.sv
tb/disk_request_scheduler_tb.sv
